// File: sv/mesh_vertex_normal_accumulate_unit_assert.svh
`ifndef MESH_VERTEX_NORMAL_ACCUMULATE_UNIT_ASSERT_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATE_UNIT_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define MVNA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while in reset
`define MVNA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers the reset itself
`define MVNA_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mvna_pkg.sv
package mvna_pkg;

    localparam int MAX_VERTICES_DEF = 4096;
    localparam int SUM_WIDTH_DEF    = 48;

    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 12;
    localparam int POS_W   = 16;
    localparam int NORM_W  = 16;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int CROSS_W = 35;
    localparam int MAG_W   = 30;
    localparam int SQ_W    = 64;
    localparam int LEN_W   = 32;
    localparam int QUO_W   = 16;

    localparam logic [NORM_W-1:0] Q_ONE = 16'd16384;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRI  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LOAD     = 2'd0;
    localparam t_kind KIND_TRI      = 2'd1;
    localparam t_kind KIND_READ     = 2'd2;
    localparam t_kind KIND_READ_OOR = 2'd3;

    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         idx;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
        logic [IDX_W-1:0]         ca;
        logic [IDX_W-1:0]         cb;
        logic [IDX_W-1:0]         cc;
    } t_cmd;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
    } t_vec;

endpackage

// File: sv/mvna_ram.sv
module mvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/mvna_front.sv
module mvna_front #(
    parameter int MAX_VERTICES = mvna_pkg::MAX_VERTICES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [mvna_pkg::FUNC_W-1:0]    i_func,
    input  logic [mvna_pkg::IDX_W-1:0]     i_vertex_index,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_z,
    input  logic [mvna_pkg::IDX_W-1:0]     i_corner_a,
    input  logic [mvna_pkg::IDX_W-1:0]     i_corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]     i_corner_c,
    input  logic                           i_hold,
    output mvna_pkg::t_cmd                 o_cmd,
    output logic                           o_cmd_valid,
    input  logic                           i_cmd_ready
);
    import mvna_pkg::*;

    localparam int DEPTH = 2;

    t_cmd       r_q [DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       keep;
    logic       vi_ok;
    logic       tri_ok;
    logic       push;
    logic       pop;

    assign vi_ok  = int'(i_vertex_index) < MAX_VERTICES;
    assign tri_ok = (int'(i_corner_a) < MAX_VERTICES) && (int'(i_corner_b) < MAX_VERTICES)
                 && (int'(i_corner_c) < MAX_VERTICES);

    // classify; unused codes and out-of-range loads/triangles are dropped here
    always_comb begin
        n_cmd.kind = KIND_LOAD;
        n_cmd.idx  = i_vertex_index;
        n_cmd.px   = i_pos_x;
        n_cmd.py   = i_pos_y;
        n_cmd.pz   = i_pos_z;
        n_cmd.ca   = i_corner_a;
        n_cmd.cb   = i_corner_b;
        n_cmd.cc   = i_corner_c;
        keep       = 1'b0;
        unique case (i_func)
            FUNC_LOAD: begin
                keep = vi_ok;
            end
            FUNC_TRI: begin
                n_cmd.kind = KIND_TRI;
                keep       = tri_ok;
            end
            FUNC_READ: begin
                n_cmd.kind = vi_ok ? KIND_READ : KIND_READ_OOR;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2) && !i_hold;
    assign push        = i_valid && o_ready && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= r_wp ^ push;
            r_rp  <= r_rp ^ pop;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: sv/mvna_norm.sv
module mvna_norm #(
    parameter int SUM_WIDTH = mvna_pkg::SUM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [SUM_WIDTH-1:0] i_sum_x,
    input  logic signed [SUM_WIDTH-1:0] i_sum_y,
    input  logic signed [SUM_WIDTH-1:0] i_sum_z,
    output logic                        o_done,
    output mvna_pkg::t_vec              o_norm
);
    import mvna_pkg::*;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DSET  = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;
    localparam logic [2:0] N_DEND  = 3'd6;

    logic [2:0]            r_st;
    logic                  r_done;
    logic [SUM_WIDTH-1:0]  r_mag [3];
    logic                  r_neg [3];
    logic [SUM_WIDTH-1:0]  r_mx;
    logic [1:0]            r_k;
    logic [2*MAG_W-1:0]    r_prod;
    logic [SQ_W-1:0]       r_n;
    logic [SQ_W-1:0]       r_root;
    logic [SQ_W-1:0]       r_bit;
    logic [LEN_W-1:0]      r_rem;
    logic [QUO_W-1:0]      r_qlo;
    logic [QUO_W-1:0]      r_quo;
    logic [3:0]            r_cnt;
    logic [NORM_W-1:0]     r_res [3];

    logic [SUM_WIDTH-1:0]  abs_x, abs_y, abs_z, mx01, mx;
    logic [SQ_W-1:0]       sq_try;
    logic [LEN_W-1:0]      len;
    logic [MAG_W+14:0]     num;
    logic [LEN_W:0]        dtry;
    logic [QUO_W-1:0]      qc;
    logic [NORM_W-1:0]     qs;

    assign abs_x = i_sum_x[SUM_WIDTH-1] ? (~i_sum_x + 1'b1) : i_sum_x;
    assign abs_y = i_sum_y[SUM_WIDTH-1] ? (~i_sum_y + 1'b1) : i_sum_y;
    assign abs_z = i_sum_z[SUM_WIDTH-1] ? (~i_sum_z + 1'b1) : i_sum_z;
    assign mx01  = (abs_x > abs_y) ? abs_x : abs_y;
    assign mx    = (mx01 > abs_z) ? mx01 : abs_z;

    assign sq_try = r_root + r_bit;
    assign len    = r_root[LEN_W-1:0];
    // numerator of the rounded quotient: mag*2^14 + len/2
    assign num    = {r_mag[0][MAG_W-1:0], 14'd0} + (MAG_W+15)'(len >> 1);
    assign dtry   = {r_rem, r_qlo[QUO_W-1]};
    assign qc     = (r_quo > Q_ONE) ? Q_ONE : r_quo;
    assign qs     = r_neg[0] ? (~qc + 16'd1) : qc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= N_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                N_IDLE: begin
                    if (i_start) begin
                        r_mag[0] <= abs_x;
                        r_mag[1] <= abs_y;
                        r_mag[2] <= abs_z;
                        r_neg[0] <= i_sum_x[SUM_WIDTH-1];
                        r_neg[1] <= i_sum_y[SUM_WIDTH-1];
                        r_neg[2] <= i_sum_z[SUM_WIDTH-1];
                        r_mx     <= mx;
                        r_st     <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    // bring the largest magnitude into [2^29, 2^30), one bit a cycle
                    if (r_mx[SUM_WIDTH-1:MAG_W] != '0) begin
                        r_mag[0] <= r_mag[0] >> 1;
                        r_mag[1] <= r_mag[1] >> 1;
                        r_mag[2] <= r_mag[2] >> 1;
                        r_mx     <= r_mx >> 1;
                    end else if (!r_mx[MAG_W-1]) begin
                        r_mag[0] <= r_mag[0] << 1;
                        r_mag[1] <= r_mag[1] << 1;
                        r_mag[2] <= r_mag[2] << 1;
                        r_mx     <= r_mx << 1;
                    end else begin
                        r_k  <= 2'd0;
                        r_n  <= '0;
                        r_st <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (r_k != 2'd3) begin
                        r_prod   <= r_mag[0][MAG_W-1:0] * r_mag[0][MAG_W-1:0];
                        r_mag[0] <= r_mag[1];
                        r_mag[1] <= r_mag[2];
                        r_mag[2] <= r_mag[0];
                    end
                    if (r_k != 2'd0) begin
                        r_n <= r_n + SQ_W'(r_prod);
                    end
                    if (r_k == 2'd3) begin
                        r_root <= '0;
                        r_bit  <= SQ_W'(1) << 62;
                        r_st   <= N_SQRT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                N_SQRT: begin
                    if (r_bit != '0) begin
                        if (r_n >= sq_try) begin
                            r_n    <= r_n - sq_try;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_k  <= 2'd0;
                        r_st <= N_DSET;
                    end
                end
                N_DSET: begin
                    r_rem <= LEN_W'(num[MAG_W+14:QUO_W]);
                    r_qlo <= num[QUO_W-1:0];
                    r_quo <= '0;
                    r_cnt <= '0;
                    r_st  <= N_DIV;
                end
                N_DIV: begin
                    if (dtry >= {1'b0, len}) begin
                        r_rem <= LEN_W'(dtry - {1'b0, len});
                        r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem <= dtry[LEN_W-1:0];
                        r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                    end
                    r_qlo <= r_qlo << 1;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_st <= N_DEND;
                    end
                end
                N_DEND: begin
                    r_res[0] <= r_res[1];
                    r_res[1] <= r_res[2];
                    r_res[2] <= qs;
                    r_mag[0] <= r_mag[1];
                    r_mag[1] <= r_mag[2];
                    r_mag[2] <= r_mag[0];
                    r_neg[0] <= r_neg[1];
                    r_neg[1] <= r_neg[2];
                    r_neg[2] <= r_neg[0];
                    if (r_k == 2'd2) begin
                        r_done <= 1'b1;
                        r_st   <= N_IDLE;
                    end else begin
                        r_k  <= r_k + 2'd1;
                        r_st <= N_DSET;
                    end
                end
                default: begin
                    r_st <= N_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_norm.x = r_res[0];
    assign o_norm.y = r_res[1];
    assign o_norm.z = r_res[2];
endmodule

// File: sv/mvna_back.sv
module mvna_back #(
    parameter int MAX_VERTICES = mvna_pkg::MAX_VERTICES_DEF,
    parameter int SUM_WIDTH    = mvna_pkg::SUM_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mvna_pkg::t_cmd                     i_cmd,
    input  logic                               i_cmd_valid,
    output logic                               o_cmd_ready,
    output logic                               o_clearing,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [mvna_pkg::NORM_W-1:0] o_norm_x,
    output logic signed [mvna_pkg::NORM_W-1:0] o_norm_y,
    output logic signed [mvna_pkg::NORM_W-1:0] o_norm_z,
    output logic                               o_degenerate,
    output logic                               o_sum_saturated
);
    import mvna_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int PW  = 3 * POS_W;
    localparam int SWW = 3 * SUM_WIDTH + 1;

    localparam logic [3:0] B_CLEAR = 4'd0;
    localparam logic [3:0] B_IDLE  = 4'd1;
    localparam logic [3:0] B_TA    = 4'd2;
    localparam logic [3:0] B_TB    = 4'd3;
    localparam logic [3:0] B_TC    = 4'd4;
    localparam logic [3:0] B_TD    = 4'd5;
    localparam logic [3:0] B_MUL   = 4'd6;
    localparam logic [3:0] B_SRD   = 4'd7;
    localparam logic [3:0] B_SWR   = 4'd8;
    localparam logic [3:0] B_RRD   = 4'd9;
    localparam logic [3:0] B_RCHK  = 4'd10;
    localparam logic [3:0] B_NORM  = 4'd11;
    localparam logic [3:0] B_OUT   = 4'd12;

    logic [3:0]                  r_st;
    logic [AW-1:0]               r_caddr;
    t_cmd                        r_cmd;
    logic signed [POS_W-1:0]     r_pa [3];
    logic signed [POS_W-1:0]     r_pb [3];
    logic signed [DIFF_W-1:0]    r_d1 [3];
    logic signed [DIFF_W-1:0]    r_d2 [3];
    logic [2:0]                  r_step;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [CROSS_W-1:0]   r_cx, r_cy, r_cz;
    logic [1:0]                  r_corner;
    logic                        r_rsat;
    t_vec                        r_stg;
    logic                        r_stg_deg;
    logic                        r_stg_sat;
    logic                        r_ov;
    t_vec                        r_out;
    logic                        r_deg;
    logic                        r_sat;

    logic                        pos_we;
    logic [AW-1:0]               pos_addr;
    logic [PW-1:0]               pos_wdata, pos_rdata;
    logic                        sum_we;
    logic [AW-1:0]               sum_addr;
    logic [SWW-1:0]              sum_wdata, sum_rdata;
    logic signed [POS_W-1:0]     q_pos [3];
    logic signed [SUM_WIDTH-1:0] rd_sx, rd_sy, rd_sz;
    logic                        rd_mark;
    logic [AW-1:0]               corner_addr;
    logic signed [DIFF_W-1:0]    op_a, op_b;
    logic signed [PROD_W-1:0]    mul;
    logic [SUM_WIDTH:0]          ax, ay, az;
    logic                        out_free;
    logic                        sum_zero;
    logic                        norm_start;
    logic                        norm_done;
    t_vec                        norm_res;

    // {overflow flag, clamped sum}
    function automatic logic [SUM_WIDTH:0] sat_add(input logic signed [SUM_WIDTH-1:0] s,
                                                   input logic signed [CROSS_W-1:0] d);
        logic signed [SUM_WIDTH:0] t;
        t = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(d);
        if (t[SUM_WIDTH] != t[SUM_WIDTH-1]) begin
            sat_add = {1'b1, t[SUM_WIDTH], {(SUM_WIDTH-1){~t[SUM_WIDTH]}}};
        end else begin
            sat_add = {1'b0, t[SUM_WIDTH-1:0]};
        end
    endfunction

    assign q_pos[0] = pos_rdata[3*POS_W-1:2*POS_W];
    assign q_pos[1] = pos_rdata[2*POS_W-1:POS_W];
    assign q_pos[2] = pos_rdata[POS_W-1:0];

    assign rd_mark = sum_rdata[3*SUM_WIDTH];
    assign rd_sx   = sum_rdata[3*SUM_WIDTH-1:2*SUM_WIDTH];
    assign rd_sy   = sum_rdata[2*SUM_WIDTH-1:SUM_WIDTH];
    assign rd_sz   = sum_rdata[SUM_WIDTH-1:0];

    assign ax = sat_add(rd_sx, r_cx);
    assign ay = sat_add(rd_sy, r_cy);
    assign az = sat_add(rd_sz, r_cz);

    always_comb begin
        unique case (r_corner)
            2'd1:    corner_addr = AW'(r_cmd.cb);
            2'd2:    corner_addr = AW'(r_cmd.cc);
            default: corner_addr = AW'(r_cmd.ca);
        endcase
    end

    // one shared multiplier walks the six cross-product terms
    always_comb begin
        unique case (r_step)
            3'd0:    begin op_a = r_d1[1]; op_b = r_d2[2]; end
            3'd1:    begin op_a = r_d1[2]; op_b = r_d2[1]; end
            3'd2:    begin op_a = r_d1[2]; op_b = r_d2[0]; end
            3'd3:    begin op_a = r_d1[0]; op_b = r_d2[2]; end
            3'd4:    begin op_a = r_d1[0]; op_b = r_d2[1]; end
            default: begin op_a = r_d1[1]; op_b = r_d2[0]; end
        endcase
    end
    assign mul = op_a * op_b;

    assign out_free    = !r_ov || i_ready;
    assign o_cmd_ready = (r_st == B_IDLE);
    assign o_clearing  = (r_st == B_CLEAR);
    assign sum_zero    = (rd_sx == '0) && (rd_sy == '0) && (rd_sz == '0);
    assign norm_start  = (r_st == B_RCHK) && !sum_zero;

    always_comb begin
        pos_we    = 1'b0;
        pos_addr  = AW'(r_cmd.ca);
        pos_wdata = {i_cmd.px, i_cmd.py, i_cmd.pz};
        sum_we    = 1'b0;
        sum_addr  = r_caddr;
        sum_wdata = '0;
        unique case (r_st)
            B_CLEAR: begin
                sum_we = 1'b1;
            end
            B_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == KIND_LOAD) begin
                    pos_we   = 1'b1;
                    pos_addr = AW'(i_cmd.idx);
                    sum_we   = 1'b1;
                    sum_addr = AW'(i_cmd.idx);
                end
            end
            B_TA: pos_addr = AW'(r_cmd.ca);
            B_TB: pos_addr = AW'(r_cmd.cb);
            B_TC: pos_addr = AW'(r_cmd.cc);
            B_SRD: sum_addr = corner_addr;
            B_SWR: begin
                sum_we    = 1'b1;
                sum_addr  = corner_addr;
                sum_wdata = {rd_mark | ax[SUM_WIDTH] | ay[SUM_WIDTH] | az[SUM_WIDTH],
                             ax[SUM_WIDTH-1:0], ay[SUM_WIDTH-1:0], az[SUM_WIDTH-1:0]};
            end
            B_RRD: sum_addr = AW'(r_cmd.idx);
            default: begin
                sum_we = 1'b0;
            end
        endcase
    end

    mvna_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_addr  (pos_addr),
        .i_wdata (pos_wdata),
        .o_rdata (pos_rdata)
    );

    mvna_ram #(.WIDTH(SWW), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_addr  (sum_addr),
        .i_wdata (sum_wdata),
        .o_rdata (sum_rdata)
    );

    mvna_norm #(.SUM_WIDTH(SUM_WIDTH)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_sum_x (rd_sx),
        .i_sum_y (rd_sy),
        .i_sum_z (rd_sz),
        .o_done  (norm_done),
        .o_norm  (norm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_CLEAR;
            r_caddr <= '0;
        end else begin
            unique case (r_st)
                B_CLEAR: begin
                    if (r_caddr == AW'(MAX_VERTICES - 1)) begin
                        r_st <= B_IDLE;
                    end else begin
                        r_caddr <= r_caddr + 1'b1;
                    end
                end
                B_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.kind)
                            KIND_TRI:  r_st <= B_TA;
                            KIND_READ: r_st <= B_RRD;
                            KIND_READ_OOR: begin
                                r_stg     <= '0;
                                r_stg_deg <= 1'b1;
                                r_stg_sat <= 1'b0;
                                r_st      <= B_OUT;
                            end
                            default: r_st <= B_IDLE;
                        endcase
                    end
                end
                B_TA: r_st <= B_TB;
                B_TB: begin
                    r_pa <= q_pos;
                    r_st <= B_TC;
                end
                B_TC: begin
                    r_pb <= q_pos;
                    r_st <= B_TD;
                end
                B_TD: begin
                    for (int k = 0; k < 3; k++) begin
                        r_d1[k] <= DIFF_W'(r_pb[k]) - DIFF_W'(r_pa[k]);
                        r_d2[k] <= DIFF_W'(q_pos[k]) - DIFF_W'(r_pa[k]);
                    end
                    r_step <= 3'd0;
                    r_st   <= B_MUL;
                end
                B_MUL: begin
                    r_prod <= mul;
                    unique case (r_step)
                        3'd1:    r_cx <= CROSS_W'(r_prod);
                        3'd2:    r_cx <= r_cx - CROSS_W'(r_prod);
                        3'd3:    r_cy <= CROSS_W'(r_prod);
                        3'd4:    r_cy <= r_cy - CROSS_W'(r_prod);
                        3'd5:    r_cz <= CROSS_W'(r_prod);
                        3'd6:    r_cz <= r_cz - CROSS_W'(r_prod);
                        default: r_cx <= r_cx;
                    endcase
                    if (r_step == 3'd6) begin
                        r_corner <= 2'd0;
                        r_st     <= B_SRD;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                B_SRD: r_st <= B_SWR;
                B_SWR: begin
                    if (r_corner == 2'd2) begin
                        r_st <= B_IDLE;
                    end else begin
                        r_corner <= r_corner + 2'd1;
                        r_st     <= B_SRD;
                    end
                end
                B_RRD: r_st <= B_RCHK;
                B_RCHK: begin
                    r_rsat <= rd_mark;
                    if (sum_zero) begin
                        r_stg     <= '0;
                        r_stg_deg <= 1'b1;
                        r_stg_sat <= rd_mark;
                        r_st      <= B_OUT;
                    end else begin
                        r_st <= B_NORM;
                    end
                end
                B_NORM: begin
                    if (norm_done) begin
                        r_stg     <= norm_res;
                        r_stg_deg <= 1'b0;
                        r_stg_sat <= r_rsat;
                        r_st      <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        r_st <= B_IDLE;
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_st == B_OUT && out_free) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == B_OUT && out_free) begin
            r_out <= r_stg;
            r_deg <= r_stg_deg;
            r_sat <= r_stg_sat;
        end
    end

    assign o_valid         = r_ov;
    assign o_norm_x        = r_out.x;
    assign o_norm_y        = r_out.y;
    assign o_norm_z        = r_out.z;
    assign o_degenerate    = r_deg;
    assign o_sum_saturated = r_sat;
endmodule

// File: sv/mesh_vertex_normal_accumulate_unit.sv
// Area-weighted vertex normals. func 0 stores a vertex position and clears its normal sum,
// func 1 adds the face cross product (b-a)x(c-a) to the saturating sums of all three corners,
// func 2 returns the sum scaled to unit length in Q1.14 (zero sum: zero normal, degenerate set).
// Items go into a two-beat queue and are worked off one at a time by a sequencer around two
// single-port memories (positions, sums): a triangle takes three position reads, six passes
// of one 17x17 multiplier and three read-modify-writes of the sums, and a read of a nonzero
// sum runs a normalising shift, the bit-serial square root and three 16-step divisions.
// After reset the sum memory is cleared, one entry a cycle, over all MAX_VERTICES entries,
// and no beat is accepted during the clearing pass.
module mesh_vertex_normal_accumulate_unit #(
    parameter int MAX_VERTICES = mvna_pkg::MAX_VERTICES_DEF,
    parameter int SUM_WIDTH    = mvna_pkg::SUM_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [mvna_pkg::FUNC_W-1:0]        i_func,
    input  logic [mvna_pkg::IDX_W-1:0]         i_vertex_index,
    input  logic signed [mvna_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [mvna_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [mvna_pkg::POS_W-1:0]  i_pos_z,
    input  logic [mvna_pkg::IDX_W-1:0]         i_corner_a,
    input  logic [mvna_pkg::IDX_W-1:0]         i_corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]         i_corner_c,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [mvna_pkg::NORM_W-1:0] o_norm_x,
    output logic signed [mvna_pkg::NORM_W-1:0] o_norm_y,
    output logic signed [mvna_pkg::NORM_W-1:0] o_norm_z,
    output logic                               o_degenerate,
    output logic                               o_sum_saturated
);
    import mvna_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_ready;
    logic clearing;

    mvna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_vertex_index (i_vertex_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_corner_a     (i_corner_a),
        .i_corner_b     (i_corner_b),
        .i_corner_c     (i_corner_c),
        .i_hold         (clearing),
        .o_cmd          (cmd),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_ready    (cmd_ready)
    );

    mvna_back #(.MAX_VERTICES(MAX_VERTICES), .SUM_WIDTH(SUM_WIDTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_ready     (cmd_ready),
        .o_clearing      (clearing),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_norm_x        (o_norm_x),
        .o_norm_y        (o_norm_y),
        .o_norm_z        (o_norm_z),
        .o_degenerate    (o_degenerate),
        .o_sum_saturated (o_sum_saturated)
    );

`include "mesh_vertex_normal_accumulate_unit_assert.svh"

    // reset always starts the clearing pass, so nothing is taken the cycle after
    `MVNA_ASSERT_RST(a_clear_after_rst, !i_rst_n, !o_ready, "beat accepted right after reset")
    // queue head must hold while the back end is busy
    `MVNA_ASSERT_NEXT(a_queue_hold, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd),
        "queue head lost while back end stalled")
    `MVNA_ASSERT_NOW(a_no_cmd_in_clear, clearing, !cmd_ready && !o_ready,
        "command taken during clearing pass")
endmodule
